// ===== hw/rtl/hff_pkg.sv =====
// Shared types, character codes and digit lookup for the hex field formatter.
// No dependencies; imported by hff_shift_unit and hex_field_formatter_unit.
package hff_pkg;

   localparam int CNT_BITS = 7;
   localparam int NIB_BITS = 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;

   typedef struct packed {
      logic load;
      logic shift;
   } hff_ctrl_type;

   // ASCII code of one hex digit in the selected case.
   function automatic logic [7:0] hex_ascii(input logic [NIB_BITS-1:0] nib,
                                            input logic upper);
      logic [7:0] base;
      if (nib < 4'd10) begin
         hex_ascii = CHAR_ZERO + 8'(nib);
      end else begin
         base = upper ? CHAR_A_UP : CHAR_A_LO;
         hex_ascii = base + 8'(nib - 4'd10);
      end
   endfunction

endpackage

// ===== hw/rtl/hff_shift_unit.sv =====
// Nibble shifter shared by the leading-zero scan and the digit emission.
// Depends on hff_pkg for the control struct and nibble width.
module hff_shift_unit
   import hff_pkg::*;
#(
   parameter int NIBS = 8
) (
   input  logic                         clock,
   input  hff_ctrl_type                 ctrl,
   input  logic [NIBS*NIB_BITS-1:0]     load_value,
   output logic [NIB_BITS-1:0]          top_nibble
);

   localparam int SH_BITS = NIBS * NIB_BITS;

   logic [SH_BITS-1:0] val_ff;

   // The most significant digit always sits in the top nibble.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         val_ff <= load_value;
      end else if (ctrl.shift) begin
         val_ff <= val_ff << NIB_BITS;
      end
   end

   assign top_nibble = val_ff[SH_BITS-1 -: NIB_BITS];

endmodule

// ===== hw/rtl/hex_field_formatter_unit.sv =====
// Hex field formatter: one ASCII character out per cycle, and results cannot be stalled.
// Synchronous active-high reset returns to idle. A transfer is taken when start is high
// and busy is low; busy then stays high until the last character is registered. Per value:
// a leading-zero scan in the shared nibble shifter, length arithmetic in the CALC_LEN and
// CALC_BOUND states, then the characters in order. The next value is taken only after the
// last character of the previous one has been registered and busy has dropped.
module hex_field_formatter_unit
   import hff_pkg::*;
#(
   parameter int MAX_CHARS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic [6:0]  req_field_width,
   input  logic [5:0]  req_min_digits,
   input  logic        req_upper_case,
   input  logic        req_alt_prefix,
   input  logic        req_left_justify,
   input  logic        req_zero_pad,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_last,
   output logic [6:0]  rsp_total_chars
);

   localparam int EFF_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int NIBS     = (EFF_BITS + NIB_BITS - 1) / NIB_BITS;
   localparam int SH_BITS  = NIBS * NIB_BITS;
   localparam int HL_BITS  = $clog2(NIBS + 1);
   localparam int PREC_MAX = MAX_CHARS - 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC_LEN,
      ST_CALC_BOUND,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   logic                busy_ff;
   logic                strobe_ff;
   logic [7:0]          char_ff;
   logic                last_ff;
   logic [CNT_BITS-1:0] count_ff;

   logic [CNT_BITS-1:0] width_ff;
   logic [CNT_BITS-1:0] prec_ff;
   logic                upper_ff;
   logic                alt_ff;
   logic                left_ff;
   logic                zpad_ff;
   logic [HL_BITS-1:0]  hlen_ff;
   logic                prefix_ff;
   logic [CNT_BITS-1:0] pad_ff;
   logic [CNT_BITS-1:0] przero_ff;
   logic [CNT_BITS-1:0] total_ff;
   logic [CNT_BITS-1:0] b1_ff;
   logic [CNT_BITS-1:0] b2_ff;
   logic [CNT_BITS-1:0] b3_ff;
   logic [CNT_BITS-1:0] b4_ff;
   logic [CNT_BITS-1:0] pos_ff;

   hff_ctrl_type        shift_ctrl;
   logic [SH_BITS-1:0]  load_value;
   logic [NIB_BITS-1:0] top_nibble;

   logic                accept;
   logic                scan_more;
   logic [CNT_BITS-1:0] hlen_ext;
   logic [CNT_BITS-1:0] ndig;
   logic                prefix;
   logic [CNT_BITS-1:0] body;
   logic [CNT_BITS-1:0] pad;
   logic                in_digits;
   logic [7:0]          char_sel;
   logic                last_sel;

   assign accept     = start && !busy_ff;
   assign load_value = SH_BITS'(req_value[EFF_BITS-1:0]);
   assign scan_more  = (top_nibble == '0) && (hlen_ff > HL_BITS'(1));
   assign hlen_ext   = CNT_BITS'(hlen_ff);
   assign in_digits  = (pos_ff >= b3_ff) && (pos_ff < b4_ff);

   always_comb begin
      shift_ctrl.load  = accept;
      shift_ctrl.shift = ((state_ff == ST_SCAN) && scan_more) ||
                         ((state_ff == ST_EMIT) && in_digits);
   end

   // Length arithmetic: digits after precision, prefix, and padding up to the width.
   always_comb begin
      ndig   = (hlen_ext > prec_ff) ? hlen_ext : prec_ff;
      prefix = alt_ff && (top_nibble != '0);
      body   = ndig + (prefix ? CNT_BITS'(2) : CNT_BITS'(0));
      pad    = (width_ff > body) ? (width_ff - body) : '0;
   end

   // Character layout: leading spaces, prefix, zeros, digits, trailing spaces.
   always_comb begin
      if (pos_ff < b1_ff) begin
         char_sel = CHAR_SPACE;
      end else if (pos_ff < b2_ff) begin
         char_sel = (pos_ff == b1_ff) ? CHAR_ZERO : (upper_ff ? CHAR_X_UP : CHAR_X_LO);
      end else if (pos_ff < b3_ff) begin
         char_sel = CHAR_ZERO;
      end else if (pos_ff < b4_ff) begin
         char_sel = hex_ascii(top_nibble, upper_ff);
      end else begin
         char_sel = CHAR_SPACE;
      end
      last_sel = ((pos_ff + CNT_BITS'(1)) == total_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  busy_ff  <= 1'b1;
                  width_ff <= (req_field_width > CNT_BITS'(MAX_CHARS)) ?
                              CNT_BITS'(MAX_CHARS) : req_field_width;
                  prec_ff  <= (CNT_BITS'(req_min_digits) > CNT_BITS'(PREC_MAX)) ?
                              CNT_BITS'(PREC_MAX) : CNT_BITS'(req_min_digits);
                  upper_ff <= req_upper_case;
                  alt_ff   <= req_alt_prefix;
                  left_ff  <= req_left_justify;
                  zpad_ff  <= req_zero_pad;
                  hlen_ff  <= HL_BITS'(NIBS);
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_more) begin
                  hlen_ff <= hlen_ff - HL_BITS'(1);
               end else begin
                  state_ff <= ST_CALC_LEN;
               end
            end
            ST_CALC_LEN: begin
               prefix_ff <= prefix;
               pad_ff    <= pad;
               przero_ff <= ndig - hlen_ext;
               total_ff  <= (width_ff > body) ? width_ff : body;
               state_ff  <= ST_CALC_BOUND;
            end
            ST_CALC_BOUND: begin
               b1_ff    <= (!left_ff && !zpad_ff) ? pad_ff : '0;
               b2_ff    <= ((!left_ff && !zpad_ff) ? pad_ff : '0) +
                           (prefix_ff ? CNT_BITS'(2) : CNT_BITS'(0));
               b3_ff    <= ((!left_ff && !zpad_ff) ? pad_ff : '0) +
                           (prefix_ff ? CNT_BITS'(2) : CNT_BITS'(0)) + przero_ff +
                           ((!left_ff && zpad_ff) ? pad_ff : '0);
               b4_ff    <= ((!left_ff && !zpad_ff) ? pad_ff : '0) +
                           (prefix_ff ? CNT_BITS'(2) : CNT_BITS'(0)) + przero_ff +
                           ((!left_ff && zpad_ff) ? pad_ff : '0) + hlen_ext;
               pos_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               strobe_ff <= 1'b1;
               char_ff   <= char_sel;
               last_ff   <= last_sel;
               count_ff  <= last_sel ? total_ff : '0;
               pos_ff    <= pos_ff + CNT_BITS'(1);
               if (last_sel) begin
                  busy_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   hff_shift_unit #(
      .NIBS (NIBS)
   ) u_shift (
      .clock      (clock),
      .ctrl       (shift_ctrl),
      .load_value (load_value),
      .top_nibble (top_nibble)
   );

   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_total_chars = count_ff;

   // The last character of a value releases busy in the same cycle it is shown.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_last |-> !busy)
      else $error("busy still high with the last character");

   // Characters before the last one belong to a value still in progress.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_last |-> busy && (rsp_total_chars == '0))
      else $error("intermediate character outside a busy value");

   // An accepted transfer makes the unit busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted without raising busy");

   // Shifts happen only in scan or emission; during emission the control shifts only in the digit region.
   a_shift_scope: assert property (@(posedge clock) disable iff (reset)
      shift_ctrl.shift |-> (state_ff == ST_SCAN) || (state_ff == ST_EMIT))
      else $error("nibble shift outside scan or emission");

endmodule
